### rtl/bsck_pkg.sv
// Shared types and constants for the byte stream cipher keystream core.
package bsck_pkg;

  localparam int unsigned KEY_BYTES_DEF = 32;
  localparam int unsigned MIX_STEPS_DEF = 256;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_ABSORB = 2'd0,
    ACT_MIX    = 2'd1,
    ACT_DATA   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_RD,
    ST_ABS_WR,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DAT_RD_I,
    ST_DAT_RD_N,
    ST_DAT_WR
  } state_e;

endpackage

### rtl/bsck_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsck_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/byte_stream_cipher_keystream_core.sv
// Top level of the byte stream cipher keystream core.
//
// Input channel (in_valid_i / in_stall_o) carries action_i, position_i and
// in_byte_i; a transaction happens when valid is high and stall is low.
// Output channel (out_valid_o / out_stall_i) carries out_byte_o, one result
// per data item, held in an output register until taken.
// The key bytes sit in one key RAM driven by a small sequencer, one RAM read
// and at most one RAM write per cycle:
//   clear, or absorb at a position beyond the state: done in the idle state
//   absorb: a read, then add and write back
//   mix: a first read, then MIX_STEPS steps, one step per cycle with the next
//     read issued while the current entry is written
//   data: two reads (current and next entry) and one write; the result is
//     loaded into the output register together with the write
// in_stall_o is high while an item is in progress. A data item waits in its
// write cycle while the output register is full and stalled; the state then
// does not advance. Reset, and a clear item, zero the accumulator, index and
// counter and mark every key entry as zero through per-entry valid bits, so
// no clearing pass is needed.
module byte_stream_cipher_keystream_core #(
  parameter int unsigned KEY_BYTES = bsck_pkg::KEY_BYTES_DEF,
  parameter int unsigned MIX_STEPS = bsck_pkg::MIX_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bsck_pkg::ACT_W-1:0]  action_i,
  input  logic [bsck_pkg::POS_W-1:0]  position_i,
  input  logic [bsck_pkg::BYTE_W-1:0] in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bsck_pkg::BYTE_W-1:0] out_byte_o
);

  import bsck_pkg::*;

  localparam int unsigned IW = $clog2(KEY_BYTES);
  localparam int unsigned CW = (MIX_STEPS > 1) ? $clog2(MIX_STEPS) : 1;

  state_e state_q, state_d;

  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [BYTE_W-1:0] bc_q, bc_d;
  logic [BYTE_W-1:0] ki_q, ki_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     q_q, q_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [KEY_BYTES-1:0] vld_q;
  logic              rd_vld_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata, rd_data;

  action_e           in_act;
  logic              in_fire, pos_ok, clr, out_load, out_free, mix_last;
  logic [IW-1:0]     idx_nx, q_nx, pos_addr;
  logic [BYTE_W-1:0] abs_new, mix_new, mix_acc, dat_new, dat_acc, ks;

  bsck_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(KEY_BYTES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_act     = action_e'(action_i);
  assign pos_ok     = (32'(position_i) < KEY_BYTES);
  assign pos_addr   = IW'(pos_q);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mix_last   = (cnt_q == CW'(MIX_STEPS - 1));

  assign idx_nx = (idx_q == IW'(KEY_BYTES - 1)) ? '0 : idx_q + IW'(1);
  assign q_nx   = (q_q == IW'(KEY_BYTES - 1)) ? '0 : q_q + IW'(1);

  // unwritten entries read as zero
  assign rd_data = rd_vld_q ? ram_rdata : '0;

  assign abs_new = rd_data + byte_q;
  assign mix_new = rd_data + acc_q;
  assign mix_acc = acc_q + mix_new + BYTE_W'(cnt_q);
  assign dat_new = ki_q + rd_data + acc_q;
  assign dat_acc = acc_q + dat_new + bc_q;
  assign ks      = (dat_acc + dat_new) ^ dat_new;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_act)
            ACT_ABSORB: state_d = pos_ok ? ST_ABS_RD : ST_IDLE;
            ACT_MIX:    state_d = ST_MIX_RD;
            ACT_DATA:   state_d = ST_DAT_RD_I;
            ACT_CLEAR:  state_d = ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ABS_RD:   state_d = ST_ABS_WR;
      ST_ABS_WR:   state_d = ST_IDLE;
      ST_MIX_RD:   state_d = ST_MIX_WR;
      ST_MIX_WR:   state_d = mix_last ? ST_IDLE : ST_MIX_WR;
      ST_DAT_RD_I: state_d = ST_DAT_RD_N;
      ST_DAT_RD_N: state_d = ST_DAT_WR;
      ST_DAT_WR:   state_d = out_free ? ST_IDLE : ST_DAT_WR;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = idx_q;
    acc_d     = acc_q;
    bc_d      = bc_q;
    idx_d     = idx_q;
    q_d       = q_q;
    cnt_d     = cnt_q;
    ki_d      = ki_q;
    clr       = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        q_d   = '0;
        clr   = in_fire && (in_act == ACT_CLEAR);
      end
      ST_ABS_RD: ram_raddr = pos_addr;
      ST_ABS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_addr;
        ram_wdata = abs_new;
        acc_d     = acc_q + abs_new;
      end
      ST_MIX_RD: ram_raddr = q_q;
      ST_MIX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = q_q;
        ram_wdata = mix_new;
        ram_raddr = q_nx;
        acc_d     = mix_acc;
        cnt_d     = cnt_q + CW'(1);
        q_d       = q_nx;
      end
      ST_DAT_RD_I: ram_raddr = idx_q;
      ST_DAT_RD_N: begin
        ram_raddr = idx_nx;
        ki_d      = rd_data;
      end
      ST_DAT_WR: begin
        ram_raddr = idx_nx;
        if (out_free) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q;
          ram_wdata = dat_new;
          acc_d     = dat_acc;
          bc_d      = bc_q + 8'd1;
          idx_d     = idx_nx;
          out_load  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      bc_q        <= '0;
      idx_q       <= '0;
      q_q         <= '0;
      cnt_q       <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      q_q      <= q_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= vld_q[ram_raddr];
      if (clr) begin
        acc_q <= '0;
        bc_q  <= '0;
        idx_q <= '0;
        vld_q <= '0;
      end else begin
        acc_q <= acc_d;
        bc_q  <= bc_d;
        idx_q <= idx_d;
        if (ram_we) begin
          vld_q[ram_waddr] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q  <= position_i;
      byte_q <= in_byte_i;
    end
    ki_q <= ki_d;
    if (out_load) begin
      out_byte_q <= byte_q ^ ks;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

### rtl/bsck_checker.sv
// Port-level checker for the keystream core, bound to the top level.
module bsck_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [bsck_pkg::ACT_W-1:0]  action_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bsck_pkg::BYTE_W-1:0] out_byte_o
);

  import bsck_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed or dropped");

  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == ACT_MIX || action_i == ACT_DATA) |=> in_stall_o)
    else $error("mix or data transaction did not occupy the core");

  a_clear_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (action_i == ACT_CLEAR) |=> !in_stall_o)
    else $error("clear transaction left the core busy");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a data item in progress");

endmodule

bind byte_stream_cipher_keystream_core bsck_checker u_bsck_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .action_i   (action_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o)
);
